FILE: rtl/lkc_pkg.sv
// lkc_pkg: shared constants, command codes and control/status types of the lru key cache
`timescale 1ns / 1ps
package lkc_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = 7;
  localparam int KEY_W   = 64;
  localparam int HND_W   = 32;
  localparam int STAT_W  = 32;
  localparam int FUNC_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_STATS  = 2'd3;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 7'd50;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the input word
    logic walk;       // read the slot at the walk index and advance
    logic upd_phase;  // walk rewrites recency ranks instead of searching
    logic decide;     // register the outcome of the search
    logic commit;     // apply the item and load the result register
  } lkc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_scan;
    logic walk_last;
    logic need_upd;
  } lkc_stat_t;

endpackage

FILE: rtl/lru_keyed_result_cache_unit.sv
// lru_keyed_result_cache_unit: top level of the fully associative lru key/handle cache
`timescale 1ns / 1ps
// Usage:
// Input words arrive on in_tvalid/in_tready: in_tuser carries the command (lookup, insert,
// clear, reset statistics), in_tdata the key and the handle. Each accepted word yields
// exactly one result word on out_tvalid/out_tready: out_tuser is the hit flag, out_tdata
// holds the found handle, the saturating hit and miss counts and the occupancy.
// cfg_valid/cfg_data write the eviction threshold (reset 50); cfg_ready is always high,
// and the threshold is to be written only while no word is in flight.
// Items are processed one at a time. Lookups and inserts walk all 64 slots through the
// single-read-port slot memories, one slot per cycle, before a lookup miss or an insert into
// a free slot commits. A lookup hit or an insert that overwrites or evicts needs a second
// 64-slot walk to rewrite the recency ranks. Clear, statistics reset and inserts of a null
// handle skip both walks.
// The result register lets the next word be accepted while a result waits; a stalled
// receiver holds back only the commit of the following item.
// Reset empties the table, zeroes both counters and restores the threshold; key, handle
// and rank memories are not cleared, since only valid slots are ever used.
module lru_keyed_result_cache_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // key [63:0], handle [95:64]
  input  logic [1:0]   in_tuser,   // func [1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // found_handle [31:0], hits_so_far [63:32],
                                   // misses_so_far [95:64], occupancy [102:96], zero pad
  output logic         out_tuser,  // hit [0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data
);
  import lkc_pkg::*;

  lkc_cmd_t          cmd;
  lkc_stat_t         st;
  logic [HND_W-1:0]  res_handle;
  logic [STAT_W-1:0] res_hits;
  logic [STAT_W-1:0] res_misses;
  logic [CNT_W-1:0]  res_occupancy;

  assign cfg_ready = 1'b1;

  lkc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  lkc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid),
    .cfg_data      (cfg_data),
    .in_func       (in_tuser),
    .in_key        (in_tdata[63:0]),
    .in_handle     (in_tdata[95:64]),
    .cmd           (cmd),
    .st            (st),
    .res_hit       (out_tuser),
    .res_handle    (res_handle),
    .res_hits      (res_hits),
    .res_misses    (res_misses),
    .res_occupancy (res_occupancy)
  );

  assign out_tdata = {1'b0, res_occupancy, res_misses, res_hits, res_handle};

endmodule

FILE: rtl/lkc_ctrl.sv
// lkc_ctrl: sequencer for search, rank update and commit of one item at a time
`timescale 1ns / 1ps
module lkc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  lkc_pkg::lkc_stat_t st,
  output lkc_pkg::lkc_cmd_t  cmd
);
  import lkc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SDRAIN = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_UPD    = 3'd4;
  localparam logic [2:0] S_UDRAIN = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!st.needs_scan) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.walk = 1'b1;
          if (st.walk_last) state_nxt = S_SDRAIN;
        end
      end
      S_SDRAIN: state_nxt = S_DECIDE;
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = st.need_upd ? S_UPD : S_COMMIT;
      end
      S_UPD: begin
        cmd.walk      = 1'b1;
        cmd.upd_phase = 1'b1;
        if (st.walk_last) state_nxt = S_UDRAIN;
      end
      S_UDRAIN: state_nxt = S_COMMIT;
      S_COMMIT: begin
        // hold the finished item until the result register can take it
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/lkc_dp.sv
// lkc_dp: slot memories, valid bits, search and rank update logic, counters and result register
`timescale 1ns / 1ps
module lkc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lkc_pkg::CNT_W-1:0]   cfg_data,
  input  logic [lkc_pkg::FUNC_W-1:0]  in_func,
  input  logic [lkc_pkg::KEY_W-1:0]   in_key,
  input  logic [lkc_pkg::HND_W-1:0]   in_handle,
  input  lkc_pkg::lkc_cmd_t           cmd,
  output lkc_pkg::lkc_stat_t          st,
  output logic                        res_hit,
  output logic [lkc_pkg::HND_W-1:0]   res_handle,
  output logic [lkc_pkg::STAT_W-1:0]  res_hits,
  output logic [lkc_pkg::STAT_W-1:0]  res_misses,
  output logic [lkc_pkg::CNT_W-1:0]   res_occupancy
);
  import lkc_pkg::*;

  // slot storage
  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [HND_W-1:0] hnd_mem [ENTRIES];
  logic [IDX_W-1:0] rec_mem [ENTRIES];
  logic [KEY_W-1:0] key_q;
  logic [HND_W-1:0] hnd_q;
  logic [IDX_W-1:0] rec_q;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   vc_r, vc_nxt;
  logic [CNT_W-1:0]   max_r;
  logic [STAT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [STAT_W-1:0]  miss_cnt_r, miss_cnt_nxt;

  // current item
  logic [FUNC_W-1:0] func_r;
  logic [KEY_W-1:0]  key_r;
  logic [HND_W-1:0]  hnd_r;
  logic              is_lookup, act_ins;

  // walk
  logic [IDX_W-1:0] idx_r;
  logic             rd_vld_r, rd_upd_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_valid;

  // search results
  logic             match_found_r, victim_found_r, free_found_r;
  logic [IDX_W-1:0] match_slot_r, match_rank_r, victim_slot_r, free_slot_r;
  logic [HND_W-1:0] match_hnd_r;

  // decision
  logic [CNT_W-1:0] lim;
  logic             evict_nxt, found_nxt, place_nxt;
  logic [IDX_W-1:0] place_slot_nxt;
  logic [CNT_W-1:0] vcn_nxt;
  logic             evict_r, found_r, place_r;
  logic [IDX_W-1:0] place_slot_r;
  logic [CNT_W-1:0] vcn_r;

  logic             rec_upd_we, rec_place_we, hnd_we;
  logic [IDX_W-1:0] rec_new, rec_wa, hnd_wa;
  logic [IDX_W-1:0] rec_wd;

  assign is_lookup = (func_r == FUNC_LOOKUP);
  assign act_ins   = (func_r == FUNC_INSERT) && (hnd_r != '0);
  assign rd_valid  = valid_r[rd_idx_r];

  assign st.needs_scan = is_lookup || act_ins;
  assign st.walk_last  = (idx_r == IDX_W'(ENTRIES - 1));
  assign st.need_upd   = found_nxt || evict_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_ENTRIES_RESET;
    end else if (cfg_we) begin
      max_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= in_key;
      hnd_r  <= in_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      rd_upd_r <= 1'b0;
    end else begin
      if (cmd.load || cmd.decide) idx_r <= '0;
      else if (cmd.walk) idx_r <= idx_r + IDX_W'(1);
      rd_vld_r <= cmd.walk;
      rd_upd_r <= cmd.upd_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk) rd_idx_r <= idx_r;
  end

  // rank rewrite: the touched entry takes the top rank; others drop one for an eviction, one more if above it
  always_comb begin
    if (found_r && (rd_idx_r == match_slot_r)) begin
      rec_new = IDX_W'(vcn_r - CNT_W'(1));
    end else begin
      rec_new = rec_q - IDX_W'(evict_r) - IDX_W'(found_r && (rec_q > match_rank_r));
    end
  end

  assign rec_upd_we   = rd_vld_r && rd_upd_r && rd_valid &&
                        !(evict_r && (rd_idx_r == victim_slot_r));
  assign rec_place_we = cmd.commit && place_r;
  assign rec_wa       = rec_place_we ? place_slot_r : rd_idx_r;
  assign rec_wd       = rec_place_we ? vcn_r[IDX_W-1:0] : rec_new;
  assign hnd_we       = cmd.commit && (place_r || (act_ins && found_r));
  assign hnd_wa       = place_r ? place_slot_r : match_slot_r;

  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      key_q <= key_mem[idx_r];
      hnd_q <= hnd_mem[idx_r];
      rec_q <= rec_mem[idx_r];
    end
    if (rec_place_we) key_mem[place_slot_r] <= key_r;
    if (hnd_we) hnd_mem[hnd_wa] <= hnd_r;
    if (rec_upd_we || rec_place_we) rec_mem[rec_wa] <= rec_wd;
  end

  // search over the walk: first matching key, the rank-zero entry, first free slot
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      match_found_r  <= 1'b0;
      victim_found_r <= 1'b0;
      free_found_r   <= 1'b0;
    end else if (rd_vld_r && !rd_upd_r) begin
      if (rd_valid && (key_q == key_r) && !match_found_r) begin
        match_found_r <= 1'b1;
        match_slot_r  <= rd_idx_r;
        match_rank_r  <= rec_q;
        match_hnd_r   <= hnd_q;
      end
      if (rd_valid && (rec_q == '0)) begin
        victim_found_r <= 1'b1;
        victim_slot_r  <= rd_idx_r;
      end
      if (!rd_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= rd_idx_r;
      end
    end
  end

  always_comb begin
    lim       = (max_r > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : max_r;
    evict_nxt = act_ins && (vc_r >= lim) && victim_found_r;
    // an evicted entry can no longer be found by key
    found_nxt = match_found_r && !(evict_nxt && (match_slot_r == victim_slot_r));
    place_nxt = act_ins && !found_nxt && (free_found_r || evict_nxt);
    if (evict_nxt && (!free_found_r || (victim_slot_r < free_slot_r))) begin
      place_slot_nxt = victim_slot_r;
    end else begin
      place_slot_nxt = free_slot_r;
    end
    vcn_nxt = vc_r - CNT_W'(evict_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evict_r <= 1'b0;
      found_r <= 1'b0;
      place_r <= 1'b0;
    end else if (cmd.decide) begin
      evict_r <= evict_nxt;
      found_r <= found_nxt;
      place_r <= place_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      place_slot_r <= place_slot_nxt;
      vcn_r        <= vcn_nxt;
    end
  end

  always_comb begin
    valid_nxt    = valid_r;
    vc_nxt       = vcn_r + CNT_W'(place_r);
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    unique case (func_r)
      FUNC_LOOKUP: begin
        vc_nxt = vc_r;
        if (found_r) begin
          if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + STAT_W'(1);
        end else if (miss_cnt_r != '1) begin
          miss_cnt_nxt = miss_cnt_r + STAT_W'(1);
        end
      end
      FUNC_INSERT: begin
        if (evict_r) valid_nxt[victim_slot_r] = 1'b0;
        if (place_r) valid_nxt[place_slot_r] = 1'b1;
      end
      FUNC_CLEAR: begin
        valid_nxt = '0;
        vc_nxt    = '0;
      end
      FUNC_STATS: begin
        vc_nxt       = vc_r;
        hit_cnt_nxt  = '0;
        miss_cnt_nxt = '0;
      end
      default: vc_nxt = vc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      vc_r       <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (cmd.commit) begin
      valid_r    <= valid_nxt;
      vc_r       <= vc_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_hit       <= is_lookup && found_r;
      res_handle    <= (is_lookup && found_r) ? match_hnd_r : '0;
      res_hits      <= hit_cnt_nxt;
      res_misses    <= miss_cnt_nxt;
      res_occupancy <= vc_nxt;
    end
  end

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(vc_r))
    else $error("occupancy count disagrees with valid bits");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r <= CNT_W'(ENTRIES))
    else $error("occupancy above table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (func_r == FUNC_CLEAR)) |=> (vc_r == '0) && (valid_r == '0))
    else $error("clear left entries valid");

  a_rec_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rec_upd_we && rec_place_we))
    else $error("two recency writes in one cycle");

endmodule
